// File: src/stk_pkg.sv
// ----------------------------------------------------------------------------
// Stack engine package
// Shared widths, command and status codes, and the control and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FILLO_W = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SWAP = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// File: src/stk_if.sv
// ----------------------------------------------------------------------------
// Stack engine channels
// Command channel and result channel, each a valid/ready handshake that
// moves one word per accepted transfer.
// ----------------------------------------------------------------------------
interface stk_in_if;
  logic                                valid;
  logic                                ready;
  logic [stk_pkg::CMD_W-1:0]           command;
  logic signed [stk_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface stk_out_if;
  logic                                valid;
  logic                                ready;
  logic [stk_pkg::STAT_W-1:0]          status;
  logic                                shown_valid;
  logic signed [stk_pkg::DATA_W-1:0]   shown_value;
  logic [stk_pkg::FILLO_W-1:0]         stack_fill;

  modport source (output valid, output status, output shown_valid, output shown_value,
                  output stack_fill, input ready);
  modport sink   (input valid, input status, input shown_valid, input shown_value,
                  input stack_fill, output ready);
endinterface

// File: src/stk_ctrl.sv
// ----------------------------------------------------------------------------
// Stack engine controller
// Takes a command word, loads the second entry into a register, then in the
// execute state fires the execute strobe once the result register is free.
// ----------------------------------------------------------------------------
module stk_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  stk_pkg::stat_t stat,
  output stk_pkg::ctl_t  ctl
);
  import stk_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl.load  = 1'b0;
    ctl.exec  = 1'b0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          ctl.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/stk_dp.sv
// ----------------------------------------------------------------------------
// Stack engine datapath
// The top entry lives in a register and the entries below it in a memory,
// so each command needs at most one memory read and one memory write.
// ----------------------------------------------------------------------------
module stk_dp #(
  parameter int unsigned STACK_DEPTH = stk_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  stk_pkg::ctl_t                      ctl,
  output stk_pkg::stat_t                     stat,
  input  logic [stk_pkg::CMD_W-1:0]          in_command,
  input  logic signed [stk_pkg::DATA_W-1:0]  in_push_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [stk_pkg::STAT_W-1:0]         out_status,
  output logic                               out_shown_valid,
  output logic signed [stk_pkg::DATA_W-1:0]  out_shown_value,
  output logic [stk_pkg::FILLO_W-1:0]        out_stack_fill
);
  import stk_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned FW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0]   mem_r [STACK_DEPTH];
  logic [CMD_W-1:0]    cmd_r;
  logic [DATA_W-1:0]   val_r;
  logic [DATA_W-1:0]   top_r;
  logic [DATA_W-1:0]   top_nxt;
  logic [DATA_W-1:0]   second_r;
  logic [FW-1:0]       fill_r;
  logic [FW-1:0]       fill_nxt;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic                wr_en;
  logic                full;
  logic                short1;
  logic                short2;

  logic                out_valid_r;
  logic [STAT_W-1:0]   status_r;
  logic [STAT_W-1:0]   status_nxt;
  logic                shown_valid_r;
  logic                shown_valid_nxt;
  logic [DATA_W-1:0]   shown_value_r;
  logic [DATA_W-1:0]   shown_value_nxt;
  logic [FILLO_W-1:0]  fill_out_r;

  assign full    = (fill_r == FW'(STACK_DEPTH));
  assign short1  = (fill_r == '0);
  assign short2  = (fill_r < FW'(2));
  assign rd_addr = AW'(fill_r - FW'(2));

  always_comb begin
    status_nxt      = ST_DONE;
    shown_valid_nxt = 1'b0;
    shown_value_nxt = '0;
    fill_nxt        = fill_r;
    top_nxt         = top_r;
    wr_en           = 1'b0;
    wr_addr         = AW'(fill_r - FW'(1));
    wr_data         = top_r;
    case (cmd_r)
      CMD_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en    = !short1;
          top_nxt  = val_r;
          fill_nxt = fill_r + FW'(1);
        end
      end
      CMD_POP: begin
        if (short1) begin
          status_nxt = ST_SHORT;
        end else begin
          top_nxt  = second_r;
          fill_nxt = fill_r - FW'(1);
        end
      end
      CMD_PEEK: begin
        if (short1) begin
          status_nxt = ST_SHORT;
        end else begin
          shown_valid_nxt = 1'b1;
          shown_value_nxt = top_r;
        end
      end
      CMD_ADD: begin
        if (short2) begin
          status_nxt = ST_SHORT;
        end else begin
          top_nxt  = second_r + top_r;
          fill_nxt = fill_r - FW'(1);
        end
      end
      CMD_SWAP: begin
        if (short2) begin
          status_nxt = ST_SHORT;
        end else begin
          top_nxt = second_r;
          wr_en   = 1'b1;
          wr_addr = rd_addr;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.load) begin
      second_r <= mem_r[rd_addr];
      cmd_r    <= in_command;
      val_r    <= in_push_value;
    end
    if (ctl.exec) begin
      top_r         <= top_nxt;
      status_r      <= status_nxt;
      shown_valid_r <= shown_valid_nxt;
      shown_value_r <= shown_value_nxt;
      fill_out_r    <= FILLO_W'(fill_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.exec) begin
        fill_r <= fill_nxt;
      end
      if (ctl.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_shown_valid = shown_valid_r;
  assign out_shown_value = shown_value_r;
  assign out_stack_fill  = fill_out_r;

endmodule

// File: src/stack_engine_push_pop_add_swap_top.sv
// Timing: a result word is registered in the execute step that follows the acceptance
// of its command word, once the result register is free, and held until it is taken.
// Flow: no new command word is taken until the last one has executed; the memory
// read of the entry below the top register comes first, execution and write second.
// A waiting result word holds the execute step, so at most one further command
// word is taken while it waits. Reset (synchronous, active low) empties the stack.
// ----------------------------------------------------------------------------
// Stack engine top level
// Bounded stack of signed 32-bit values with push, pop, peek, add and swap.
// ----------------------------------------------------------------------------
module stack_engine_push_pop_add_swap_top #(
  parameter int unsigned STACK_DEPTH = stk_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  stk_in_if.sink     in_if,
  stk_out_if.source  out_if
);
  import stk_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  stk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  stk_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_command      (in_if.command),
    .in_push_value   (in_if.push_value),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_status      (out_if.status),
    .out_shown_valid (out_if.shown_valid),
    .out_shown_value (out_if.shown_value),
    .out_stack_fill  (out_if.stack_fill)
  );

endmodule

// File: sim/tb_stack_engine_push_pop_add_swap_top.sv
// ----------------------------------------------------------------------------
// Stack engine testbench
// A short table of directed commands first covers the empty, single-entry and
// full stack, wrap on add and unknown commands. Random command sequences then
// swing the stack between shallow and deep. Every result word is compared
// field by field with its typed result or a behavioral copy of the stack, while
// both channels idle at random outside a calm stretch in the random part.
// ----------------------------------------------------------------------------
module tb_stack_engine_push_pop_add_swap_top;
  import stk_pkg::*;

  localparam logic [CMD_W-1:0] CMD_BAD_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BAD_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD_HI  = 3'd7;
  localparam int unsigned RANDOM_WORDS   = 320;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned IDLE_PCT       = 19;
  localparam int unsigned DIR_ROWS       = 24;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               shown_valid;
    logic [DATA_W-1:0]  shown_value;
    logic [FILLO_W-1:0] stack_fill;
  } stk_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] push_value;
    logic              typed;
    stk_result_t       want;
  } cmd_word_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [DATA_W-1:0]  push_value;
    logic [6:0]         reps;
    logic               typed;
    logic [STAT_W-1:0]  status;
    logic               shown_valid;
    logic [DATA_W-1:0]  shown_value;
    logic [FILLO_W-1:0] stack_fill;
  } dir_row_t;

  // Rows without a typed result are checked against the behavioral stack.
  dir_row_t dir_table [DIR_ROWS] = '{
    '{CMD_POP,     32'h0,        7'd1,  1'b1, ST_SHORT, 1'b0, 32'h0,        7'd0},
    '{CMD_PEEK,    32'h0,        7'd1,  1'b1, ST_SHORT, 1'b0, 32'h0,        7'd0},
    '{CMD_ADD,     32'h0,        7'd1,  1'b1, ST_SHORT, 1'b0, 32'h0,        7'd0},
    '{CMD_SWAP,    32'h0,        7'd1,  1'b1, ST_SHORT, 1'b0, 32'h0,        7'd0},
    '{CMD_BAD_LO,  32'hFFFFFFFF, 7'd1,  1'b1, ST_DONE,  1'b0, 32'h0,        7'd0},
    '{CMD_PUSH,    32'h7FFFFFFF, 7'd1,  1'b1, ST_DONE,  1'b0, 32'h0,        7'd1},
    '{CMD_PEEK,    32'h0,        7'd1,  1'b1, ST_DONE,  1'b1, 32'h7FFFFFFF, 7'd1},
    '{CMD_ADD,     32'h0,        7'd1,  1'b1, ST_SHORT, 1'b0, 32'h0,        7'd1},
    '{CMD_SWAP,    32'h0,        7'd1,  1'b1, ST_SHORT, 1'b0, 32'h0,        7'd1},
    '{CMD_PUSH,    32'h80000000, 7'd1,  1'b1, ST_DONE,  1'b0, 32'h0,        7'd2},
    '{CMD_SWAP,    32'h0,        7'd1,  1'b1, ST_DONE,  1'b0, 32'h0,        7'd2},
    '{CMD_PEEK,    32'h0,        7'd1,  1'b1, ST_DONE,  1'b1, 32'h7FFFFFFF, 7'd2},
    '{CMD_PUSH,    32'h1,        7'd1,  1'b1, ST_DONE,  1'b0, 32'h0,        7'd3},
    '{CMD_ADD,     32'h0,        7'd1,  1'b0, ST_DONE,  1'b0, 32'h0,        7'd0},
    '{CMD_PEEK,    32'h0,        7'd1,  1'b0, ST_DONE,  1'b0, 32'h0,        7'd0},
    '{CMD_ADD,     32'h0,        7'd1,  1'b0, ST_DONE,  1'b0, 32'h0,        7'd0},
    '{CMD_BAD_MID, 32'h12345678, 7'd1,  1'b1, ST_DONE,  1'b0, 32'h0,        7'd1},
    '{CMD_BAD_HI,  32'hFFFFFFFF, 7'd1,  1'b1, ST_DONE,  1'b0, 32'h0,        7'd1},
    '{CMD_POP,     32'h0,        7'd1,  1'b1, ST_DONE,  1'b0, 32'h0,        7'd0},
    '{CMD_POP,     32'h0,        7'd1,  1'b1, ST_SHORT, 1'b0, 32'h0,        7'd0},
    '{CMD_PUSH,    32'hFFFFFFFF, 7'd64, 1'b0, ST_DONE,  1'b0, 32'h0,        7'd0},
    '{CMD_PUSH,    32'h0,        7'd1,  1'b1, ST_FULL,  1'b0, 32'h0,        7'd64},
    '{CMD_PEEK,    32'h0,        7'd1,  1'b1, ST_DONE,  1'b1, 32'hFFFFFFFF, 7'd64},
    '{CMD_ADD,     32'h0,        7'd1,  1'b0, ST_DONE,  1'b0, 32'h0,        7'd0}
  };

  logic clk;
  logic rst_n;

  stk_in_if  in_ch();
  stk_out_if out_ch();

  stack_engine_push_pop_add_swap_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  cmd_word_t   cmd_q[$];
  stk_result_t result_q[$];
  cmd_word_t   cur_word;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH_DEF];
  int unsigned       depth_cnt = 0;

  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned quiet_cycles  = 0;
  logic        calm;

  // The middle of the random part runs with no idling on either side.
  assign calm = (words_sent >= 150) && (words_sent < 260);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic stk_result_t stack_predict(input logic [CMD_W-1:0]  cmd,
                                                input logic [DATA_W-1:0] val);
    stk_result_t       r;
    logic [DATA_W-1:0] held;
    r = '0;
    case (cmd)
      CMD_PUSH: begin
        if (depth_cnt >= STACK_DEPTH_DEF) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[depth_cnt] = val;
          depth_cnt++;
        end
      end
      CMD_POP: begin
        if (depth_cnt == 0) r.status = ST_SHORT;
        else depth_cnt--;
      end
      CMD_PEEK: begin
        if (depth_cnt == 0) begin
          r.status = ST_SHORT;
        end else begin
          r.shown_valid = 1'b1;
          r.shown_value = stack_mem[depth_cnt-1];
        end
      end
      CMD_ADD: begin
        if (depth_cnt < 2) begin
          r.status = ST_SHORT;
        end else begin
          stack_mem[depth_cnt-2] = stack_mem[depth_cnt-2] + stack_mem[depth_cnt-1];
          depth_cnt--;
        end
      end
      CMD_SWAP: begin
        if (depth_cnt < 2) begin
          r.status = ST_SHORT;
        end else begin
          held                   = stack_mem[depth_cnt-1];
          stack_mem[depth_cnt-1] = stack_mem[depth_cnt-2];
          stack_mem[depth_cnt-2] = held;
        end
      end
      default: begin
      end
    endcase
    r.stack_fill = FILLO_W'(depth_cnt);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'h7FFFFFFF;
      3: return 32'h80000000;
      4: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // The mix of commands follows a bias that is redrawn every 30 to 90 words, so
  // the stack grows toward full, drains toward empty, or wanders in between.
  function automatic logic [CMD_W-1:0] pick_command(input int unsigned bias);
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    roll     = $urandom_range(0, 99);
    push_pct = (bias == 0) ? 70 : (bias == 1) ? 20 : 38;
    pop_pct  = (bias == 0) ? 6  : (bias == 1) ? 36 : 20;
    if (roll < push_pct) return CMD_PUSH;
    roll -= push_pct;
    if (roll < pop_pct) return CMD_POP;
    roll -= pop_pct;
    if (roll < 4) return 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
    case ($urandom_range(0, 2))
      0: return CMD_PEEK;
      1: return CMD_ADD;
      default: return CMD_SWAP;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("mismatch on result word %0d: %s got %h want %h", words_checked, field,
             got, want);
    mismatch_cnt++;
  endtask

  // Command side: one word held on the channel until it is taken.
  always @(posedge clk) begin : drive_commands
    stk_result_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        r = stack_predict(cur_word.command, cur_word.push_value);
        result_q.push_back(cur_word.typed ? cur_word.want : r);
        words_sent <= words_sent + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_word          = cmd_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.command    <= cur_word.command;
          in_ch.push_value <= cur_word.push_value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure and the field-by-field comparison.
  always @(posedge clk) begin : check_results
    stk_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("word with nothing expected", DATA_W'(out_ch.status), '0);
        end else begin
          want = result_q.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", DATA_W'(out_ch.status), DATA_W'(want.status));
          if (out_ch.shown_valid !== want.shown_valid)
            report_mismatch("shown_valid", DATA_W'(out_ch.shown_valid),
                            DATA_W'(want.shown_valid));
          if (out_ch.shown_value !== want.shown_value)
            report_mismatch("shown_value", out_ch.shown_value, want.shown_value);
          if (out_ch.stack_fill !== want.stack_fill)
            report_mismatch("stack_fill", DATA_W'(out_ch.stack_fill),
                            DATA_W'(want.stack_fill));
        end
        words_checked++;
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : run_test
    cmd_word_t   w;
    int unsigned bias;
    int unsigned run_left;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_PUSH;
    in_ch.push_value = '0;
    out_ch.ready     = 1'b0;

    foreach (dir_table[i]) begin
      w.command    = dir_table[i].command;
      w.push_value = dir_table[i].push_value;
      w.typed      = dir_table[i].typed;
      w.want       = '{dir_table[i].status, dir_table[i].shown_valid,
                       dir_table[i].shown_value, dir_table[i].stack_fill};
      repeat (dir_table[i].reps) cmd_q.push_back(w);
    end

    run_left = 0;
    bias     = 0;
    repeat (RANDOM_WORDS) begin
      if (run_left == 0) begin
        bias     = $urandom_range(0, 2);
        run_left = $urandom_range(30, 90);
      end
      run_left--;
      w.command    = pick_command(bias);
      w.push_value = pick_value();
      w.typed      = 1'b0;
      w.want       = '0;
      cmd_q.push_back(w);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() > 0 || in_ch.valid || result_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
src/stk_pkg.sv
src/stk_if.sv
src/stk_ctrl.sv
src/stk_dp.sv
src/stack_engine_push_pop_add_swap_top.sv
sim/tb_stack_engine_push_pop_add_swap_top.sv
